### sv/htw_pkg.sv
// Shared types and request codes for the hashed timing wheel.
package htw_pkg;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;

    localparam int ID_BITS     = 4;
    localparam int PERIOD_W    = 12;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [ID_BITS-1:0]  timer_id;
        logic [PERIOD_W-1:0] period;
    } req_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0] expired_id;
        logic               last;
    } rsp_item_t;

endpackage

### sv/htw_front.sv
// Request intake: accepts requests, drops those with no effect, and queues the rest.
module htw_front
    import htw_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_data,
    output logic      cmd_valid,
    input  logic      cmd_pop,
    output req_item_t cmd_data
);

    req_item_t   q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        accept;
    logic        keep;
    logic        id_ok;
    logic        push;
    logic        pop;

    assign req_ready = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd_data  = q_reg[rd_ptr_reg];
    assign accept    = req_valid && req_ready;
    assign id_ok     = (32'(req_data.timer_id) < NUM_TIMERS);

    always_comb
    begin
        case (req_data.req_type)
            REQ_TICK: keep = 1'b1;
            REQ_ADD:  keep = id_ok;
            REQ_DEL:  keep = id_ok;
            default:  keep = 1'b0;
        endcase
    end

    assign push = accept && keep;
    assign pop  = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req_data;
        end
    end

endmodule

### sv/htw_divider.sv
// Divider by the constant wheel size through a reciprocal multiply, one register stage.
module htw_divider #(
    parameter int PERIOD_BITS = 12,
    parameter int WHEEL_SLOTS = 10
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [PERIOD_BITS-1:0]         dividend,
    output logic                           done,
    output logic [PERIOD_BITS-1:0]         quotient,
    output logic [$clog2(WHEEL_SLOTS)-1:0] remainder
);

    localparam int RB = $clog2(WHEEL_SLOTS);
    localparam int SH = PERIOD_BITS + RB;
    localparam int XW = 2 * PERIOD_BITS + RB;
    // The reciprocal is rounded up, which keeps the quotient exact for every
    // dividend of PERIOD_BITS bits.
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);

    logic [XW-1:0]          product;
    logic [PERIOD_BITS-1:0] quot_reg;
    logic [PERIOD_BITS-1:0] dvd_reg;
    logic                   done_reg;
    logic [PERIOD_BITS-1:0] quot_times_slots;

    assign product          = XW'(dividend) * XW'(RECIP);
    assign quot_times_slots = quot_reg * PERIOD_BITS'(WHEEL_SLOTS);
    assign done             = done_reg;
    assign quotient         = quot_reg;
    assign remainder        = RB'(dvd_reg - quot_times_slots);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            quot_reg <= '0;
            dvd_reg  <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                quot_reg <= product[SH +: PERIOD_BITS];
                dvd_reg  <= dividend;
            end
        end
    end

endmodule

### sv/htw_engine.sv
// Command execution: timer table, wheel position, tick walk and expiry output.
module htw_engine
    import htw_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int WHEEL_SLOTS = 10,
    parameter int PERIOD_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  req_item_t cmd_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_data
);

    localparam int IW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PW     = PERIOD_BITS;
    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int STEP_W = $clog2(WHEEL_SLOTS + 1);
    localparam longint unsigned MAXQ = ((64'd1 << PW) - 64'd2) / WHEEL_SLOTS;
    localparam int RW     = (MAXQ == 0) ? 1 : $clog2(MAXQ + 1);
    localparam logic [PERIOD_W-1:0] PMASK = PERIOD_W'((64'd1 << PW) - 64'd1);

    // Each entry keeps its reload count and slot step so that a re-arm
    // needs no division: period - 1 = reload * WHEEL_SLOTS + (step - 1).
    typedef struct packed {
        logic [SLOT_W-1:0] home;
        logic [RW-1:0]     rounds;
        logic [RW-1:0]     reload;
        logic [STEP_W-1:0] step;
    } entry_t;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_WALK, ST_FLUSH} state_t;

    function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
                                                   logic [STEP_W-1:0] s);
        logic [STEP_W:0] t;
        t = (STEP_W+1)'(a) + (STEP_W+1)'(s);
        if (t >= (STEP_W+1)'(WHEEL_SLOTS))
        begin
            t = t - (STEP_W+1)'(WHEEL_SLOTS);
        end
        return SLOT_W'(t);
    endfunction

    entry_t mem [NUM_TIMERS];
    entry_t rd_data_reg;

    state_t              state_reg, state_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [IW-1:0]       add_id_reg, add_id_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic                issue_reg, issue_next;
    logic                p_valid_reg, p_valid_next;
    logic [IW-1:0]       p_idx_reg, p_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IW-1:0]       pend_id_reg, pend_id_next;
    logic                out_valid_reg, out_valid_next;
    rsp_item_t           out_data_reg, out_data_next;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;

    logic                div_start;
    logic [PW-1:0]       div_dividend;
    logic                div_done;
    logic [PW-1:0]       div_quot;
    logic [SLOT_W-1:0]   div_rem;

    logic [PERIOD_W-1:0] per_field;
    logic [PW-1:0]       per;
    logic [STEP_W-1:0]   add_step;
    logic                out_free;
    logic                p_match;
    logic                p_due;
    logic                advance;

    htw_divider #(
        .PERIOD_BITS(PERIOD_BITS),
        .WHEEL_SLOTS(WHEEL_SLOTS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign per_field    = cmd_data.period & PMASK;
    assign per          = (per_field == '0) ? PW'(1) : PW'(per_field);
    assign div_dividend = per - PW'(1);
    assign add_step     = STEP_W'(div_rem) + STEP_W'(1);

    assign out_free  = !out_valid_reg || rsp_ready;
    assign p_match   = p_valid_reg && armed_reg[p_idx_reg] && (rd_data_reg.home == pos_reg);
    assign p_due     = p_match && (rd_data_reg.rounds == '0);
    // The walk holds only when a second expiry turns up while the held one cannot leave.
    assign advance   = !(p_due && pend_valid_reg && !out_free);

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        pos_next        = pos_reg;
        add_id_next     = add_id_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        p_valid_next    = p_valid_reg;
        p_idx_next      = p_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_data_next   = out_data_reg;
        cmd_pop         = 1'b0;
        div_start       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = p_idx_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_data.req_type)
                        REQ_TICK:
                        begin
                            pos_next = (pos_reg == SLOT_W'(WHEEL_SLOTS - 1)) ?
                                       '0 : pos_reg + SLOT_W'(1);
                            rd_idx_next     = '0;
                            issue_next      = 1'b1;
                            p_valid_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_WALK;
                        end
                        REQ_ADD:
                        begin
                            div_start   = 1'b1;
                            add_id_next = IW'(cmd_data.timer_id);
                            state_next  = ST_DIV;
                        end
                        REQ_DEL:
                        begin
                            armed_next[IW'(cmd_data.timer_id)] = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = add_id_reg;
                    mem_wdata.home   = slot_add(pos_reg, add_step);
                    mem_wdata.rounds = RW'(div_quot);
                    mem_wdata.reload = RW'(div_quot);
                    mem_wdata.step   = add_step;
                    armed_next[add_id_reg] = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    if (issue_reg)
                    begin
                        mem_re       = 1'b1;
                        p_valid_next = 1'b1;
                        p_idx_next   = rd_idx_reg;
                        if (rd_idx_reg == IW'(NUM_TIMERS - 1))
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            rd_idx_next = rd_idx_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        p_valid_next = 1'b0;
                        state_next   = ST_FLUSH;
                    end

                    if (p_match)
                    begin
                        mem_we = 1'b1;
                        if (p_due)
                        begin
                            mem_wdata.home   = slot_add(rd_data_reg.home, rd_data_reg.step);
                            mem_wdata.rounds = rd_data_reg.reload;
                        end
                        else
                        begin
                            mem_wdata.rounds = rd_data_reg.rounds - RW'(1);
                        end
                    end

                    // One expiry is held back until the next one, or the end of
                    // the walk, shows whether it is the last of this tick.
                    if (p_due)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next           = 1'b1;
                            out_data_next.expired_id = ID_BITS'(pend_id_reg);
                            out_data_next.last       = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = p_idx_reg;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.expired_id = ID_BITS'(pend_id_reg);
                    out_data_next.last       = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            armed_reg      <= '0;
            pos_reg        <= '0;
            add_id_reg     <= '0;
            rd_idx_reg     <= '0;
            issue_reg      <= 1'b0;
            p_valid_reg    <= 1'b0;
            p_idx_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            pos_reg        <= pos_next;
            add_id_reg     <= add_id_next;
            rd_idx_reg     <= rd_idx_next;
            issue_reg      <= issue_next;
            p_valid_reg    <= p_valid_next;
            p_idx_reg      <= p_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_id_reg    <= pend_id_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

endmodule

### sv/hashed_timing_wheel.sv
// Hashed timing wheel top level: periodic timers over a wheel of slots.
// The req channel (req_valid, req_ready, req_data) takes one request per
// transfer: a tick, an add or re-arm of a timer with a period, or a delete.
// Requests that cannot have an effect are dropped at intake. The rsp channel
// (rsp_valid, rsp_ready, rsp_data) carries one transfer per expired timer in
// ascending id order, with last set on the final expiry of a tick; a tick
// with no expiry sends nothing.
// Requests pass through a two-entry queue to the execution engine, so the
// intake keeps taking requests while the engine works or waits on rsp.
// An add passes through the engine's idle and divide states, the divide by
// the wheel size done as a registered reciprocal multiply; a delete needs only
// the idle state. A tick walks the timer table one entry per cycle while the
// walk is not held, reading and writing back entries on separate ports.
// When rsp stalls, the walk pauses once an expiry is due while one waits in
// the output register and another is held back; the queue then fills and
// req_ready drops. Reset disarms all timers, sets the wheel position to zero
// and empties the queue and output register.
module hashed_timing_wheel
    import htw_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int WHEEL_SLOTS = 10,
    parameter int PERIOD_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_data
);

    logic      cmd_valid;
    logic      cmd_pop;
    req_item_t cmd_data;

    htw_front #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data)
    );

    htw_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .WHEEL_SLOTS(WHEEL_SLOTS),
        .PERIOD_BITS(PERIOD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
